@@ src/wdls_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdls_pkg
// Shared types and codes for the weave delta line selector.
// ----------------------------------------------------------------------------
package wdls_pkg;

    // default table size and register reset
    localparam int unsigned TABLE_DEPTH_DEF = 1024;
    localparam logic [9:0]  LAST_SEQ_RESET  = 10'd1023;

    // request commands
    localparam logic [1:0] CMD_START_INS = 2'd0;
    localparam logic [1:0] CMD_START_DEL = 2'd1;
    localparam logic [1:0] CMD_END       = 2'd2;
    localparam logic [1:0] CMD_MARK      = 2'd3;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_SEQ   = 3'd1;
    localparam logic [2:0] ST_INS_OPEN  = 3'd2;
    localparam logic [2:0] ST_DEL_OPEN  = 3'd3;
    localparam logic [2:0] ST_UNMATCHED = 3'd4;

    // block kinds
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_DELETE = 1'b1;

    // dispositions
    localparam logic [1:0] DISP_NONE     = 2'd0;
    localparam logic [1:0] DISP_INCLUDED = 2'd1;

    typedef struct packed {
        logic [1:0] command;
        logic [9:0] seq_number;
        logic [1:0] disposition;
    } request_t;

    typedef struct packed {
        logic [2:0] status;
        logic       keep_lines;
        logic [9:0] active_insert_seq;
    } result_t;

    // one table entry
    typedef struct packed {
        logic       open;
        logic       kind;
        logic [1:0] disp;
    } entry_t;

    // outcome of a table scan
    typedef struct packed {
        logic       keep;
        logic       upd_insert;
        logic [9:0] insert_seq;
    } verdict_t;

endpackage

@@ src/wdls_scan.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdls_scan
// Tracks the highest open included delete, included insert and other insert
// over a stream of table entries read in ascending order, and forms the verdict.
// ----------------------------------------------------------------------------
module wdls_scan #(
    parameter int unsigned IDX_W = 10
) (
    input  logic                 aclk,
    input  logic                 start,
    input  logic                 smp_vld,
    input  logic [IDX_W-1:0]     smp_idx,
    input  wdls_pkg::entry_t     smp_entry,
    output wdls_pkg::verdict_t   verdict
);

    logic [IDX_W-1:0] hi_inc_ins_reg;
    logic [IDX_W-1:0] hi_inc_del_reg;
    logic [IDX_W-1:0] hi_oth_ins_reg;
    logic             inc;

    assign inc = (smp_entry.disp == wdls_pkg::DISP_INCLUDED);

    // ascending order: a later hit is always the highest so far
    always_ff @(posedge aclk) begin
        if (start) begin
            hi_inc_ins_reg <= '0;
            hi_inc_del_reg <= '0;
            hi_oth_ins_reg <= '0;
        end else if (smp_vld && smp_entry.open) begin
            if (smp_entry.kind == wdls_pkg::KIND_INSERT) begin
                if (inc) begin
                    hi_inc_ins_reg <= smp_idx;
                end else begin
                    hi_oth_ins_reg <= smp_idx;
                end
            end else if (inc) begin
                hi_inc_del_reg <= smp_idx;
            end
        end
    end

    // keep if top included insert is above top included delete and other insert
    always_comb begin
        verdict.keep       = 1'b0;
        verdict.upd_insert = 1'b0;
        verdict.insert_seq = 10'(hi_inc_ins_reg);
        if (hi_inc_del_reg > hi_inc_ins_reg) begin
            verdict.keep = 1'b0;
        end else if (hi_inc_ins_reg > hi_oth_ins_reg) begin
            verdict.keep       = 1'b1;
            verdict.upd_insert = 1'b1;
        end
    end

endmodule

@@ src/weave_delta_line_selector.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weave_delta_line_selector
// Keeps per-delta disposition and open-block state in one table memory and
// decides whether weave body lines are kept after each block start or end.
// ----------------------------------------------------------------------------
//  channel   direction  ports                          payload
//  request   in         s_valid s_ready s_request      command, seq, disposition
//  result    out        m_valid m_ready m_result       status, keep, insert seq
//  config    in         cfg_wr_en cfg_wr_data          last_seq
//
//  Marks and rejected requests go from acceptance through S_DECIDE to S_DONE.
//  Block starts and ends rescan entries 0..min(last_seq, TABLE_DEPTH-1) through
//  the single table read port, one entry per cycle, then pass S_SCAN_LAST,
//  S_EVAL and S_DONE. After reset a clearing pass writes every entry with
//  s_ready low. A new request is taken while a result still waits in m_result;
//  a stalled result holds the block in its final state until it is taken.
// ----------------------------------------------------------------------------
module weave_delta_line_selector #(
    parameter int unsigned TABLE_DEPTH = wdls_pkg::TABLE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  wdls_pkg::request_t  s_request,
    output logic                m_valid,
    input  logic                m_ready,
    output wdls_pkg::result_t   m_result,
    input  logic                cfg_wr_en,
    input  logic [9:0]          cfg_wr_data
);

    localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

    localparam logic [2:0] S_CLEAR     = 3'd0;
    localparam logic [2:0] S_IDLE      = 3'd1;
    localparam logic [2:0] S_DECIDE    = 3'd2;
    localparam logic [2:0] S_SCAN      = 3'd3;
    localparam logic [2:0] S_SCAN_LAST = 3'd4;
    localparam logic [2:0] S_EVAL      = 3'd5;
    localparam logic [2:0] S_DONE      = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [9:0]          last_seq_reg;
    wdls_pkg::request_t  req_reg;
    logic [2:0]          status_reg, status_next;
    logic [IDX_W-1:0]    cnt_reg, cnt_next;
    logic                rd_vld_reg;
    logic [IDX_W-1:0]    rd_idx_reg;
    wdls_pkg::entry_t    rd_data_reg;
    logic                insert_flag_reg;
    logic [9:0]          current_insert_reg;
    logic                m_valid_reg;
    wdls_pkg::result_t   m_result_reg;

    wdls_pkg::entry_t    mem [TABLE_DEPTH];
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    wdls_pkg::entry_t    mem_wdata;
    logic [IDX_W-1:0]    mem_raddr;

    logic                req_bad;
    logic [IDX_W-1:0]    top;
    logic                scan_start;
    wdls_pkg::verdict_t  verdict;
    logic                out_free;

    // handshake outputs
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;
    assign out_free = !m_valid_reg || m_ready;

    // range checks
    assign req_bad = (32'(req_reg.seq_number) > 32'(last_seq_reg))
                  || (32'(req_reg.seq_number) >= 32'(TABLE_DEPTH));
    assign top = (32'(last_seq_reg) >= 32'(TABLE_DEPTH)) ? IDX_LAST
                                                          : IDX_W'(last_seq_reg);

    // table memory, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    // control sequencer
    always_comb begin
        state_next  = state_reg;
        status_next = status_reg;
        cnt_next    = cnt_reg;
        mem_we      = 1'b0;
        mem_waddr   = IDX_W'(req_reg.seq_number);
        mem_wdata   = rd_data_reg;
        mem_raddr   = cnt_reg;
        scan_start  = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = '0;
                if (cnt_reg == IDX_LAST) begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end else begin
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end
            S_IDLE: begin
                mem_raddr = IDX_W'(s_request.seq_number);
                if (s_valid) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                status_next = wdls_pkg::ST_OK;
                state_next  = S_DONE;
                if (req_bad) begin
                    status_next = wdls_pkg::ST_BAD_SEQ;
                end else if (req_reg.command == wdls_pkg::CMD_MARK) begin
                    mem_we         = 1'b1;
                    mem_wdata.disp = req_reg.disposition;
                end else if (req_reg.command == wdls_pkg::CMD_END) begin
                    if (rd_data_reg.open) begin
                        mem_we         = 1'b1;
                        mem_wdata.open = 1'b0;
                        mem_wdata.kind = wdls_pkg::KIND_INSERT;
                        scan_start     = 1'b1;
                        cnt_next       = '0;
                        state_next     = S_SCAN;
                    end else begin
                        status_next = wdls_pkg::ST_UNMATCHED;
                    end
                end else if (rd_data_reg.open) begin
                    status_next = (rd_data_reg.kind == wdls_pkg::KIND_INSERT)
                                ? wdls_pkg::ST_INS_OPEN : wdls_pkg::ST_DEL_OPEN;
                end else begin
                    mem_we         = 1'b1;
                    mem_wdata.open = 1'b1;
                    mem_wdata.kind = (req_reg.command == wdls_pkg::CMD_START_INS)
                                   ? wdls_pkg::KIND_INSERT : wdls_pkg::KIND_DELETE;
                    scan_start     = 1'b1;
                    cnt_next       = '0;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN: begin
                mem_raddr = cnt_reg;
                if (cnt_reg == top) begin
                    state_next = S_SCAN_LAST;
                end else begin
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end
            S_SCAN_LAST: begin
                state_next = S_EVAL;
            end
            S_EVAL: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= S_CLEAR;
            cnt_reg            <= '0;
            rd_vld_reg         <= 1'b0;
            last_seq_reg       <= wdls_pkg::LAST_SEQ_RESET;
            insert_flag_reg    <= 1'b0;
            current_insert_reg <= '0;
            m_valid_reg        <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            rd_vld_reg <= (state_reg == S_SCAN);
            if (cfg_wr_en) begin
                last_seq_reg <= cfg_wr_data;
            end
            if (state_reg == S_EVAL) begin
                insert_flag_reg <= verdict.keep;
                if (verdict.upd_insert) begin
                    current_insert_reg <= verdict.insert_seq;
                end
            end
            if (state_reg == S_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        rd_idx_reg <= cnt_reg;
        status_reg <= status_next;
        if (s_valid && s_ready) begin
            req_reg <= s_request;
        end
        if (state_reg == S_DONE && out_free) begin
            m_result_reg.status            <= status_reg;
            m_result_reg.keep_lines        <= insert_flag_reg;
            m_result_reg.active_insert_seq <= current_insert_reg;
        end
    end

    // scan trackers
    wdls_scan #(
        .IDX_W (IDX_W)
    ) u_scan (
        .aclk      (aclk),
        .start     (scan_start),
        .smp_vld   (rd_vld_reg),
        .smp_idx   (rd_idx_reg),
        .smp_entry (rd_data_reg),
        .verdict   (verdict)
    );

    // checks
    a_accept_to_decide: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_DECIDE))
        else $error("accepted request did not reach decide");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (cnt_reg <= top))
        else $error("scan counter past top entry");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside done");

    a_flag_only_on_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_EVAL) |=> $stable(current_insert_reg) || $past(!aresetn))
        else $error("active insert changed outside evaluation");

endmodule
